// ----- rtl/core/bbc_pkg.sv -----
// bracket balance checker package: character codes, status codes, result type
// and bracket decode functions; no dependencies
`default_nettype none

package bbc_pkg;

  localparam int STACK_DEPTH_DEF = 4096;
  localparam int CHAR_W          = 8;
  localparam int DEPTH_W         = 13;

  localparam logic [CHAR_W-1:0] CH_OPEN_PAREN  = 8'h28;  // (
  localparam logic [CHAR_W-1:0] CH_CLOSE_PAREN = 8'h29;  // )
  localparam logic [CHAR_W-1:0] CH_OPEN_BRACE  = 8'h7B;  // {
  localparam logic [CHAR_W-1:0] CH_CLOSE_BRACE = 8'h7D;  // }
  localparam logic [CHAR_W-1:0] CH_OPEN_SQ     = 8'h5B;  // [
  localparam logic [CHAR_W-1:0] CH_CLOSE_SQ    = 8'h5D;  // ]
  localparam logic [CHAR_W-1:0] CH_OPEN_ANGLE  = 8'h3C;  // <
  localparam logic [CHAR_W-1:0] CH_CLOSE_ANGLE = 8'h3E;  // >

  typedef logic [1:0] bbc_kind_t;

  localparam bbc_kind_t KIND_PAREN = 2'd0;
  localparam bbc_kind_t KIND_BRACE = 2'd1;
  localparam bbc_kind_t KIND_SQ    = 2'd2;
  localparam bbc_kind_t KIND_ANGLE = 2'd3;

  typedef enum logic [2:0] {
    ST_RUNNING     = 3'd0,
    ST_BALANCED    = 3'd1,
    ST_MISMATCH    = 3'd2,
    ST_EMPTY_CLOSE = 3'd3,
    ST_OVERFLOW    = 3'd4,
    ST_UNCLOSED    = 3'd5
  } bbc_status_t;

  typedef struct packed {
    logic      hit;
    bbc_kind_t kind;
  } bbc_decode_t;

  typedef struct packed {
    bbc_status_t        check_status;
    logic               stream_done;
    logic [DEPTH_W-1:0] nest_depth;
  } bbc_result_t;

  function automatic bbc_decode_t open_kind(input logic [CHAR_W-1:0] c);
    bbc_decode_t d;
    d.hit  = 1'b1;
    d.kind = KIND_PAREN;
    case (c)
      CH_OPEN_PAREN: d.kind = KIND_PAREN;
      CH_OPEN_BRACE: d.kind = KIND_BRACE;
      CH_OPEN_SQ:    d.kind = KIND_SQ;
      CH_OPEN_ANGLE: d.kind = KIND_ANGLE;
      default:       d.hit  = 1'b0;
    endcase
    return d;
  endfunction

  function automatic bbc_decode_t close_kind(input logic [CHAR_W-1:0] c);
    bbc_decode_t d;
    d.hit  = 1'b1;
    d.kind = KIND_PAREN;
    case (c)
      CH_CLOSE_PAREN: d.kind = KIND_PAREN;
      CH_CLOSE_BRACE: d.kind = KIND_BRACE;
      CH_CLOSE_SQ:    d.kind = KIND_SQ;
      CH_CLOSE_ANGLE: d.kind = KIND_ANGLE;
      default:        d.hit  = 1'b0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bbc_if.sv -----
// valid/ready channel interfaces for the character input and the result output
// depends on bbc_pkg
`default_nettype none

interface bbc_in_if
  import bbc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_byte;
  logic              last_char;

  modport source (output valid, output char_byte, output last_char, input ready);
  modport sink   (input valid, input char_byte, input last_char, output ready);
endinterface

interface bbc_out_if
  import bbc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [2:0]         check_status;
  logic               stream_done;
  logic [DEPTH_W-1:0] nest_depth;

  modport source (output valid, output check_status, output stream_done,
                  output nest_depth, input ready);
  modport sink   (input valid, input check_status, input stream_done,
                  input nest_depth, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bbc_stack_mem.sv -----
// bracket kind stack storage: one write port, one read port, registered read
// depends on bbc_pkg
`default_nettype none

module bbc_stack_mem
  import bbc_pkg::*;
#(
  parameter int DEPTH  = STACK_DEPTH_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire bbc_kind_t         wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output bbc_kind_t              rd_data
);

  bbc_kind_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/bbc_out_reg.sv -----
// result output register: takes a new result whenever the slot is empty or drained
// depends on bbc_pkg and bbc_if
`default_nettype none

module bbc_out_reg
  import bbc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        res_valid,
  input  wire bbc_result_t res_data,
  output logic             res_ready,
  bbc_out_if.source        out_ch
);

  logic        valid;
  bbc_result_t data;

  assign res_ready = !valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res_ready) begin
      valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      data <= res_data;
    end
  end

  assign out_ch.valid        = valid;
  assign out_ch.check_status = data.check_status;
  assign out_ch.stream_done  = data.stream_done;
  assign out_ch.nest_depth   = data.nest_depth;

endmodule

`default_nettype wire

// ----- rtl/core/bracket_balance_checker_unit.sv -----
// result: each result is captured in the output register when its byte is taken
// throughput: one byte per cycle unless the output stalls; the top of stack and the
// entry below it sit in registers; each pop's stack memory read refills the lower one
// reset: synchronous, clears depth count, error and output valid; stack memory
// contents stay undefined and need no clearing pass
// depends on bbc_pkg, bbc_if, bbc_stack_mem, bbc_out_reg
`default_nettype none

module bracket_balance_checker_unit
  import bbc_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  bbc_in_if.sink    in_ch,
  bbc_out_if.source out_ch
);

  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

  logic [CNT_W-1:0] count, count_next;
  bbc_status_t      err, err_next;
  bbc_kind_t        top, top_next;
  bbc_kind_t        under, under_next;
  logic             under_mem, under_mem_next;

  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  bbc_kind_t         wr_data, rd_data;
  bbc_kind_t         under_cur;

  bbc_decode_t  dec_open, dec_close;
  bbc_status_t  err_step;
  logic [CNT_W-1:0] count_step;
  logic [CNT_W-1:0] count_sub3;
  bbc_result_t  res;
  logic         res_ready;
  logic         accept;

  assign accept       = in_ch.valid && res_ready;
  assign in_ch.ready  = res_ready;
  assign dec_open     = open_kind(in_ch.char_byte);
  assign dec_close    = close_kind(in_ch.char_byte);
  // entry below the top is in the memory read register right after a pop
  assign under_cur    = under_mem ? rd_data : under;
  assign count_sub3   = count - CNT_W'(3);

  always_comb begin
    count_step     = count;
    err_step       = err;
    top_next       = top;
    under_next     = under_cur;
    under_mem_next = under_mem;
    wr_en          = 1'b0;
    wr_addr        = count[ADDR_W-1:0];
    wr_data        = dec_open.kind;
    rd_en          = 1'b0;
    rd_addr        = count_sub3[ADDR_W-1:0];
    if (accept) begin
      under_mem_next = 1'b0;
      if (err == ST_RUNNING) begin
        if (dec_open.hit) begin
          if (count >= CNT_W'(STACK_DEPTH)) begin
            err_step = ST_OVERFLOW;
          end else begin
            wr_en      = 1'b1;
            top_next   = dec_open.kind;
            under_next = top;
            count_step = count + CNT_W'(1);
          end
        end else if (dec_close.hit) begin
          if (count == '0) begin
            err_step = ST_EMPTY_CLOSE;
          end else begin
            rd_en          = 1'b1;
            under_mem_next = 1'b1;
            top_next       = under_cur;
            count_step     = count - CNT_W'(1);
            if (top != dec_close.kind) begin
              err_step = ST_MISMATCH;
            end
          end
        end
      end
    end
  end

  always_comb begin
    res.stream_done = in_ch.last_char;
    res.nest_depth  = DEPTH_W'(count_step);
    res.check_status = err_step;
    count_next      = count_step;
    err_next        = err_step;
    if (in_ch.last_char) begin
      if (err_step == ST_RUNNING) begin
        res.check_status = (count_step == '0) ? ST_BALANCED : ST_UNCLOSED;
      end
      if (accept) begin
        count_next = '0;
        err_next   = ST_RUNNING;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      err       <= ST_RUNNING;
      under_mem <= 1'b0;
    end else begin
      count     <= count_next;
      err       <= err_next;
      under_mem <= under_mem_next;
    end
  end

  always_ff @(posedge clk) begin
    top   <= top_next;
    under <= under_next;
  end

  bbc_stack_mem #(
    .DEPTH  (STACK_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_stack_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bbc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (in_ch.valid),
    .res_data  (res),
    .res_ready (res_ready),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
